// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file cmas_checker.sv.
// No dependencies; include guard keeps a second include harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the given clock and reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication on the given clock and reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/cmas_pkg.sv =====
// Shared constants, types and helper functions of the moving average stats unit.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package cmas_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int MAX_COLUMNS = 65536;

   localparam int CFG_W    = 7;
   localparam int SAMPLE_W = 16;
   localparam int COL_W    = 16;
   localparam int Q_W      = 16;
   localparam int PTR_W    = $clog2(MAX_WINDOW);
   localparam int EW_W     = PTR_W + 1;
   localparam int SUM_W    = SAMPLE_W + PTR_W;
   localparam int CNT_W    = $clog2(MAX_COLUMNS) + 1;
   localparam int TOTAL_W  = SAMPLE_W + CNT_W - 1;
   localparam int STEP_W   = $clog2(Q_W);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;
      logic update;
      logic cfg_wr;
      logic div_start;
      logic div_avg;
      logic cap_smooth;
      logic cap_avg;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic smooth_go;
      logic last;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

   // Zero counts as one, anything above the line depth saturates.
   function automatic logic [EW_W-1:0] eff_window(input logic [CFG_W-1:0] raw);
      int unsigned      r;
      logic [EW_W-1:0] w;
      r = raw;
      if (r == 0) begin
         w = EW_W'(1);
      end else if (r > MAX_WINDOW) begin
         w = EW_W'(MAX_WINDOW);
      end else begin
         w = EW_W'(r);
      end
      return w;
   endfunction

endpackage

// ===== sv/cmas_req_if.sv =====
// Input channel: one column score per transfer.
// Depends on cmas_pkg for the sample width.
interface cmas_req_if;
   logic                          valid;
   logic                          ready;
   logic [cmas_pkg::SAMPLE_W-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== sv/cmas_rsp_if.sv =====
// Result channel: smoothed value and end-of-profile statistics.
// Depends on cmas_pkg for the field widths.
interface cmas_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cmas_pkg::COL_W-1:0] column;
   logic [cmas_pkg::Q_W-1:0]   smoothed;
   logic                       smooth_valid;
   logic                       done_res;
   logic                       too_short;
   logic [cmas_pkg::Q_W-1:0]   max_smoothed;
   logic [cmas_pkg::Q_W-1:0]   min_smoothed;
   logic [cmas_pkg::Q_W-1:0]   average;

   modport source (output valid, output column, output smoothed, output smooth_valid,
                   output done_res, output too_short, output max_smoothed,
                   output min_smoothed, output average, input ready);
   modport sink (input valid, input column, input smoothed, input smooth_valid,
                 input done_res, input too_short, input max_smoothed,
                 input min_smoothed, input average, output ready);
endinterface

// ===== sv/cmas_csr_if.sv =====
// Configuration write channel carrying the window size register.
// Depends on cmas_pkg for the register width.
interface cmas_csr_if;
   logic                       valid;
   logic                       ready;
   logic [cmas_pkg::CFG_W-1:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink (input valid, input window_size, output ready);
endinterface

// ===== sv/centered_moving_average_stats_unit.sv =====
// Centered boxcar moving average over a stream of unsigned Q8.8 column scores, with the
// minimum and maximum of the smoothed values and the mean of the raw scores on the last
// column. One column is in flight at a time: a column that yields no result passes only
// through the update state, a smoothed column also runs the shared 16-step radix-2
// divider; the last column runs the divider a second time for the mean. A result that
// finds the output register still occupied waits for it. A finished result waits in an
// output register while the next column is taken. A write to window_size is taken only
// between columns and restarts the profile. The delay line memory has no clearing pass
// and is ready right after reset.
module centered_moving_average_stats_unit (
   input  logic        clock,
   input  logic        reset,
   cmas_req_if.sink    req_chan,
   cmas_rsp_if.source  rsp_chan,
   cmas_csr_if.sink    csr_chan
);

   cmas_pkg::ctrl_cmd_type  cmd;
   cmas_pkg::dp_status_type status;

   cmas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .csr_valid (csr_chan.valid),
      .status    (status),
      .req_ready (req_chan.ready),
      .csr_ready (csr_chan.ready),
      .cmd       (cmd)
   );

   cmas_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_chan.sample),
      .req_last         (req_chan.last),
      .csr_window_size  (csr_chan.window_size),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_column       (rsp_chan.column),
      .rsp_smoothed     (rsp_chan.smoothed),
      .rsp_smooth_valid (rsp_chan.smooth_valid),
      .rsp_done_res     (rsp_chan.done_res),
      .rsp_too_short    (rsp_chan.too_short),
      .rsp_max_smoothed (rsp_chan.max_smoothed),
      .rsp_min_smoothed (rsp_chan.min_smoothed),
      .rsp_average      (rsp_chan.average)
   );

endmodule

// ===== sv/cmas_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, for quotients below 2**Q_W.
// Depends on cmas_pkg for widths.
module cmas_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cmas_pkg::TOTAL_W-1:0] dividend,
   input  logic [cmas_pkg::CNT_W-1:0]   divisor,
   output logic [cmas_pkg::Q_W-1:0]     quotient,
   output logic                         done
);

   logic [cmas_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [cmas_pkg::Q_W-1:0]    quo_ff, quo_in;
   logic [cmas_pkg::CNT_W-1:0]  dvs_ff;
   logic [cmas_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [cmas_pkg::CNT_W:0]    trial;
   logic [cmas_pkg::CNT_W:0]    diff;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[cmas_pkg::Q_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // upper part is below the divisor since the quotient fits Q_W bits
         rem_in  = cmas_pkg::CNT_W'(dividend[cmas_pkg::TOTAL_W-1:cmas_pkg::Q_W]);
         quo_in  = dividend[cmas_pkg::Q_W-1:0];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[cmas_pkg::CNT_W-1:0] : trial[cmas_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[cmas_pkg::Q_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == cmas_pkg::STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== sv/cmas_dp.sv =====
// Datapath: window delay line memory, running sums and statistics, divider, result register.
// Depends on cmas_pkg and cmas_div; steered by cmas_ctrl through the command struct.
module cmas_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  cmas_pkg::ctrl_cmd_type        cmd,
   output cmas_pkg::dp_status_type       status,
   input  logic [cmas_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_last,
   input  logic [cmas_pkg::CFG_W-1:0]    csr_window_size,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [cmas_pkg::COL_W-1:0]    rsp_column,
   output logic [cmas_pkg::Q_W-1:0]      rsp_smoothed,
   output logic                          rsp_smooth_valid,
   output logic                          rsp_done_res,
   output logic                          rsp_too_short,
   output logic [cmas_pkg::Q_W-1:0]      rsp_max_smoothed,
   output logic [cmas_pkg::Q_W-1:0]      rsp_min_smoothed,
   output logic [cmas_pkg::Q_W-1:0]      rsp_average
);

   logic [cmas_pkg::SAMPLE_W-1:0] line_mem [cmas_pkg::MAX_WINDOW];

   // profile state
   logic [cmas_pkg::CFG_W-1:0]   win_size_ff, win_size_in;
   logic [cmas_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cmas_pkg::SUM_W-1:0]   win_sum_ff, win_sum_in;
   logic [cmas_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [cmas_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [cmas_pkg::Q_W-1:0]     max_ff, max_in;
   logic [cmas_pkg::Q_W-1:0]     min_ff, min_in;
   logic                         any_ff, any_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic [cmas_pkg::SAMPLE_W-1:0] sample_ff;
   logic                          last_ff;
   logic [cmas_pkg::SAMPLE_W-1:0] old_ff;
   logic [cmas_pkg::COL_W-1:0]    col_ff;
   logic                          go_ff;
   logic [cmas_pkg::Q_W-1:0]      smooth_ff;
   logic [cmas_pkg::Q_W-1:0]      avg_ff;

   // result register
   logic [cmas_pkg::COL_W-1:0] out_col_ff;
   logic [cmas_pkg::Q_W-1:0]   out_smooth_ff;
   logic                       out_sv_ff;
   logic                       out_done_ff;
   logic                       out_short_ff;
   logic [cmas_pkg::Q_W-1:0]   out_max_ff;
   logic [cmas_pkg::Q_W-1:0]   out_min_ff;
   logic [cmas_pkg::Q_W-1:0]   out_avg_ff;

   logic [cmas_pkg::EW_W-1:0]    win;
   logic [cmas_pkg::CNT_W-1:0]   win_ext;
   logic [cmas_pkg::PTR_W-1:0]   old_addr;
   logic [cmas_pkg::CNT_W-1:0]   count_inc;
   logic                         keep;
   logic                         full_before;
   logic                         smooth_go;
   logic                         restart;
   logic                         div_start_go;
   logic [cmas_pkg::TOTAL_W-1:0] div_dividend;
   logic [cmas_pkg::CNT_W-1:0]   div_divisor;
   logic [cmas_pkg::Q_W-1:0]     div_quotient;
   logic                         div_done;

   assign win       = cmas_pkg::eff_window(win_size_ff);
   assign win_ext   = cmas_pkg::CNT_W'(win);
   assign old_addr  = wr_ptr_ff - win[cmas_pkg::PTR_W-1:0];
   assign count_inc = count_ff + 1'b1;
   assign keep      = count_ff < cmas_pkg::CNT_W'(cmas_pkg::MAX_COLUMNS);
   assign full_before = count_ff >= win_ext;
   assign smooth_go = keep && (count_inc >= win_ext);
   assign restart   = cmd.cfg_wr || (cmd.load_rsp && last_ff);

   always_comb begin
      win_size_in  = win_size_ff;
      wr_ptr_in    = wr_ptr_ff;
      win_sum_in   = win_sum_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update && keep) begin
         // drop the oldest sample once the window is full
         win_sum_in = win_sum_ff - (full_before ? cmas_pkg::SUM_W'(old_ff) : '0)
                      + cmas_pkg::SUM_W'(sample_ff);
         wr_ptr_in  = wr_ptr_ff + 1'b1;
         total_in   = total_ff + cmas_pkg::TOTAL_W'(sample_ff);
         count_in   = count_inc;
      end
      if (cmd.cap_smooth) begin
         any_in = 1'b1;
         if (div_quotient > max_ff) begin
            max_in = div_quotient;
         end
         if (div_quotient < min_ff) begin
            min_in = div_quotient;
         end
      end
      if (cmd.cfg_wr) begin
         win_size_in = csr_window_size;
      end
      if (restart) begin
         wr_ptr_in  = '0;
         win_sum_in = '0;
         count_in   = '0;
         total_in   = '0;
         max_in     = '0;
         min_in     = '1;
         any_in     = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= cmas_pkg::CFG_W'(1);
         wr_ptr_ff    <= '0;
         win_sum_ff   <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         max_ff       <= '0;
         min_ff       <= '1;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_size_ff  <= win_size_in;
         wr_ptr_ff    <= wr_ptr_in;
         win_sum_ff   <= win_sum_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // delay line: read the outgoing entry on transfer, write the new one on update
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         old_ff <= line_mem[old_addr];
      end
      if (cmd.update && keep) begin
         line_mem[wr_ptr_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         last_ff   <= req_last;
      end
      if (cmd.update) begin
         go_ff  <= smooth_go;
         col_ff <= count_ff[cmas_pkg::COL_W-1:0] - cmas_pkg::COL_W'(win >> 1);
      end
      if (cmd.cap_smooth) begin
         smooth_ff <= div_quotient;
      end
      if (cmd.cap_avg) begin
         avg_ff <= div_quotient;
      end
      if (cmd.load_rsp) begin
         out_col_ff    <= go_ff ? col_ff : '0;
         out_smooth_ff <= go_ff ? smooth_ff : '0;
         out_sv_ff     <= go_ff;
         out_done_ff   <= last_ff;
         out_short_ff  <= last_ff && (count_ff < win_ext);
         out_max_ff    <= (last_ff && any_ff) ? max_ff : '0;
         out_min_ff    <= (last_ff && any_ff) ? min_ff : '0;
         out_avg_ff    <= last_ff ? avg_ff : '0;
      end
   end

   assign div_start_go = cmd.div_start;
   assign div_dividend = cmd.div_avg ? total_ff : cmas_pkg::TOTAL_W'(win_sum_ff);
   assign div_divisor  = cmd.div_avg ? count_ff : win_ext;

   cmas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   assign status.smooth_go = smooth_go;
   assign status.last      = last_ff;
   assign status.div_done  = div_done;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column       = out_col_ff;
   assign rsp_smoothed     = out_smooth_ff;
   assign rsp_smooth_valid = out_sv_ff;
   assign rsp_done_res     = out_done_ff;
   assign rsp_too_short    = out_short_ff;
   assign rsp_max_smoothed = out_max_ff;
   assign rsp_min_smoothed = out_min_ff;
   assign rsp_average      = out_avg_ff;

endmodule

// ===== sv/cmas_ctrl.sv =====
// Controller: one column: update, then as needed smoothing divide, average divide, output.
// Depends on cmas_pkg for the command and status structs.
module cmas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    csr_valid,
   input  cmas_pkg::dp_status_type status,
   output logic                    req_ready,
   output logic                    csr_ready,
   output cmas_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_UPDATE  = 7'b0000010,
      ST_SM_GO   = 7'b0000100,
      ST_SM_WAIT = 7'b0001000,
      ST_AV_GO   = 7'b0010000,
      ST_AV_WAIT = 7'b0100000,
      ST_OUT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      idle;

   assign idle      = state_ff == ST_IDLE;
   // configuration takes precedence over a column in the same cycle
   assign csr_ready = idle;
   assign req_ready = idle && !csr_valid;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.cfg_wr     = idle && csr_valid;
      cmd.accept     = req_ready && req_valid;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.smooth_go) begin
               state_in = ST_SM_GO;
            end else if (status.last) begin
               state_in = ST_AV_GO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SM_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SM_WAIT;
         end
         ST_SM_WAIT: begin
            if (status.div_done) begin
               cmd.cap_smooth = 1'b1;
               state_in       = status.last ? ST_AV_GO : ST_OUT;
            end
         end
         ST_AV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_avg   = 1'b1;
            state_in      = ST_AV_WAIT;
         end
         ST_AV_WAIT: begin
            if (status.div_done) begin
               cmd.cap_avg = 1'b1;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register is free
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/cmas_checker.sv =====
// Port-level checks of the moving average stats unit, bound to the top level.
// Depends on cmas_pkg for widths and on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module cmas_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [cmas_pkg::COL_W-1:0] column,
   input logic [cmas_pkg::Q_W-1:0]   smoothed,
   input logic                       smooth_valid,
   input logic                       done_res,
   input logic                       too_short,
   input logic [cmas_pkg::Q_W-1:0]   max_smoothed,
   input logic [cmas_pkg::Q_W-1:0]   min_smoothed,
   input logic [cmas_pkg::Q_W-1:0]   average
);

   // a stalled result keeps its value
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(smoothed))
   // one column at a time
   `ASSERT_NEXT(a_one_column, clock, reset, req_valid && req_ready, !req_ready)
   // every result carries a smoothed value or closes a profile
   `ASSERT_IMPLY(a_rsp_kind, clock, reset, rsp_valid, smooth_valid || done_res)
   // statistics are zero except on the closing result
   `ASSERT_IMPLY(a_stats_zero, clock, reset, rsp_valid && !done_res, too_short == 1'b0 && max_smoothed == '0 && min_smoothed == '0 && average == '0)
   // a short profile never produced a smoothed value
   `ASSERT_IMPLY(a_short, clock, reset, rsp_valid && too_short, !smooth_valid && column == '0 && max_smoothed == '0 && min_smoothed == '0)

endmodule

bind centered_moving_average_stats_unit cmas_checker u_cmas_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .column       (rsp_chan.column),
   .smoothed     (rsp_chan.smoothed),
   .smooth_valid (rsp_chan.smooth_valid),
   .done_res     (rsp_chan.done_res),
   .too_short    (rsp_chan.too_short),
   .max_smoothed (rsp_chan.max_smoothed),
   .min_smoothed (rsp_chan.min_smoothed),
   .average      (rsp_chan.average)
);

// ===== tb/tb.sv =====
// Self-checking bench for centered_moving_average_stats_unit: drives column scores,
// rewrites the window size between phases and checks every result against a local model.
// Depends on cmas_pkg and the cmas_req_if, cmas_rsp_if and cmas_csr_if interfaces.
module tb;

   // A correct run stays under CYCLE_LIMIT even with every column at the longest gap and stall.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_CYC   = 30;
   localparam int HOLD_CYC     = 600;
   localparam int PER_SETTING  = 88;
   localparam int NUM_SETTINGS = 10;

   localparam int MAX_WINDOW  = cmas_pkg::MAX_WINDOW;
   localparam int MAX_COLUMNS = cmas_pkg::MAX_COLUMNS;
   localparam int CFG_W       = cmas_pkg::CFG_W;
   localparam int SAMPLE_W    = cmas_pkg::SAMPLE_W;
   localparam int COL_W       = cmas_pkg::COL_W;
   localparam int Q_W         = cmas_pkg::Q_W;
   localparam int PTR_W       = cmas_pkg::PTR_W;
   localparam int SUM_W       = cmas_pkg::SUM_W;
   localparam int CNT_W       = cmas_pkg::CNT_W;
   localparam int TOTAL_W     = cmas_pkg::TOTAL_W;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      bit                  drain_first;
   } column_item_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [Q_W-1:0]   smoothed;
      logic             smooth_valid;
      logic             done_res;
      logic             too_short;
      logic [Q_W-1:0]   max_smoothed;
      logic [Q_W-1:0]   min_smoothed;
      logic [Q_W-1:0]   average;
   } stats_result_type;

   logic clock;
   logic reset;

   cmas_req_if req_bus ();
   cmas_rsp_if rsp_bus ();
   cmas_csr_if csr_bus ();

   centered_moving_average_stats_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   column_item_type  column_q[$];
   stats_result_type expected_stats_q[$];

   // Local copy of the block state.
   logic [SAMPLE_W-1:0] line_mem [0:MAX_WINDOW-1];
   logic [PTR_W-1:0]    wr_ptr;
   logic [SUM_W-1:0]    win_sum;
   logic [CNT_W-1:0]    col_count;
   logic [TOTAL_W-1:0]  raw_total;
   logic [Q_W-1:0]      peak_hi;
   logic [Q_W-1:0]      peak_lo;
   bit                  seen_smoothed;
   logic [CFG_W-1:0]    win_reg;

   int  error_count;
   int  cycle_count;
   int  columns_sent;
   int  results_seen;
   int  profiles_seen;
   int  short_seen;
   int  settings_seen;
   bit  idle_on;
   bit  rsp_hold;
   bit  hold_go;
   int  send_gap;
   int  rsp_run;
   bit  rsp_open;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [CFG_W-1:0] clamp_window(input logic [CFG_W-1:0] raw);
      if (raw == 0) return CFG_W'(1);
      if (raw > MAX_WINDOW) return CFG_W'(MAX_WINDOW);
      return raw;
   endfunction

   function automatic void restart_profile();
      wr_ptr        = '0;
      win_sum       = '0;
      col_count     = '0;
      raw_total     = '0;
      peak_hi       = '0;
      peak_lo       = '1;
      seen_smoothed = 0;
   endfunction

   // Advance the model by one column; return 1 when the column yields a result.
   function automatic bit predict_column(input logic [SAMPLE_W-1:0] smp, input logic lst,
                                         output stats_result_type r);
      logic [CFG_W-1:0] w;
      logic [CNT_W-1:0] idx;
      logic [PTR_W-1:0] old_ptr;
      logic [SUM_W-1:0] mean;
      w = clamp_window(win_reg);
      r = '0;
      if (col_count < MAX_COLUMNS) begin
         idx = col_count;
         if (idx >= w) begin
            // Window of 64 wraps onto the slot about to be written.
            old_ptr = wr_ptr - w[PTR_W-1:0];
            win_sum = win_sum - line_mem[old_ptr];
         end
         line_mem[wr_ptr] = smp;
         win_sum   = win_sum + smp;
         wr_ptr    = wr_ptr + 1'b1;
         raw_total = raw_total + smp;
         col_count = idx + 1'b1;
         if (idx + 1 >= w) begin
            mean           = win_sum / w;
            r.column       = COL_W'(idx - w / 2);
            r.smoothed     = mean[Q_W-1:0];
            r.smooth_valid = 1'b1;
            seen_smoothed  = 1;
            if (mean[Q_W-1:0] > peak_hi) peak_hi = mean[Q_W-1:0];
            if (mean[Q_W-1:0] < peak_lo) peak_lo = mean[Q_W-1:0];
         end
      end
      if (!r.smooth_valid && !lst) return 0;
      if (lst) begin
         r.done_res  = 1'b1;
         r.too_short = (col_count < w);
         if (seen_smoothed) begin
            r.max_smoothed = peak_hi;
            r.min_smoothed = peak_lo;
         end
         if (col_count != 0) r.average = Q_W'(raw_total / col_count);
         restart_profile();
      end
      return 1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return SAMPLE_W'($urandom_range(0, 15));
      return SAMPLE_W'($urandom);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic queue_column(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input bit drain);
      column_item_type it;
      it.sample      = smp;
      it.last        = lst;
      it.drain_first = drain;
      column_q.push_back(it);
   endtask

   task automatic queue_profile(input int len, input bit closed, input bit drain);
      for (int i = 0; i < len; i++)
         queue_column(pick_sample(), closed && (i == len - 1), drain && (i == 0));
   endtask

   // Wait until nothing is pending or expected, then let in-flight columns finish.
   task automatic settle();
      while (column_q.size() != 0 || expected_stats_q.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.window_size <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      win_reg = value;
      restart_profile();
      settings_seen++;
   endtask

   // Driver: offer queued columns, hold each until its transfer.
   always @(posedge clock) begin
      stats_result_type res;
      bit               offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = 0;
         if (req_bus.valid && req_bus.ready) begin
            if (predict_column(req_bus.sample, req_bus.last, res))
               expected_stats_q.push_back(res);
            void'(column_q.pop_front());
            columns_sent++;
            send_gap = idle_on ? pick_gap() : 0;
         end else if (req_bus.valid) begin
            offer = 1;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (column_q.size() != 0 &&
                         !(column_q[0].drain_first && expected_stats_q.size() != 0)) begin
               offer = 1;
               req_bus.sample <= column_q[0].sample;
               req_bus.last   <= column_q[0].last;
            end
         end
         req_bus.valid <= offer;
      end
   end

   // Monitor: take results with random back-pressure and compare with the oldest expectation.
   always @(posedge clock) begin
      stats_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_run  = 0;
         rsp_open = 1;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_stats_q.size() == 0) begin
               report_mismatch("result with no expectation waiting");
            end else begin
               want = expected_stats_q.pop_front();
               results_seen++;
               if (want.done_res) profiles_seen++;
               if (want.too_short) short_seen++;
               check_field("column", rsp_bus.column, want.column);
               check_field("smoothed", rsp_bus.smoothed, want.smoothed);
               check_field("smooth_valid", rsp_bus.smooth_valid, want.smooth_valid);
               check_field("done_res", rsp_bus.done_res, want.done_res);
               check_field("too_short", rsp_bus.too_short, want.too_short);
               check_field("max_smoothed", rsp_bus.max_smoothed, want.max_smoothed);
               check_field("min_smoothed", rsp_bus.min_smoothed, want.min_smoothed);
               check_field("average", rsp_bus.average, want.average);
            end
         end
         if (rsp_run > 0) begin
            rsp_run--;
         end else if (!idle_on || $urandom_range(0, 9) < 7) begin
            rsp_open = 1;
            rsp_run  = idle_on ? $urandom_range(0, 11) : 0;
         end else begin
            rsp_open = 0;
            rsp_run  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 60);
         end
         rsp_bus.ready <= rsp_open && !rsp_hold;
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input.
   initial begin
      rsp_hold = 0;
      while (!hold_go) @(posedge clock);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYC) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_stats_q.size());
         $display("** centered_moving_average_stats_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [CFG_W-1:0] v;
      logic [CFG_W-1:0] w;
      int               n;
      int               len;
      int               r;
      bit               first;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.sample      = '0;
      req_bus.last        = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.window_size = '0;
      idle_on             = 1;
      hold_go             = 0;
      error_count         = 0;
      cycle_count         = 0;
      columns_sent        = 0;
      results_seen        = 0;
      profiles_seen       = 0;
      short_seen          = 0;
      settings_seen       = 0;
      win_reg             = CFG_W'(1);
      restart_profile();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset window of one: full-scale swings, then a single-column profile.
      queue_column('1, 1'b0, 1'b0);
      queue_column('0, 1'b0, 1'b0);
      queue_column('1, 1'b1, 1'b0);
      queue_column('0, 1'b1, 1'b1);
      settle();

      // Short profile, then a normal one.
      write_window(CFG_W'(3));
      queue_column(SAMPLE_W'(5), 1'b0, 1'b0);
      queue_column(SAMPLE_W'(9), 1'b1, 1'b0);
      queue_column('1, 1'b0, 1'b1);
      queue_column('0, 1'b0, 1'b0);
      queue_column('1, 1'b0, 1'b0);
      queue_column(SAMPLE_W'(1), 1'b0, 1'b0);
      queue_column(SAMPLE_W'(2), 1'b1, 1'b0);
      settle();

      // Zero window acts as one; leave a profile open so the next write restarts it.
      write_window(CFG_W'(0));
      queue_column(SAMPLE_W'(1234), 1'b1, 1'b0);
      queue_column(SAMPLE_W'(100), 1'b0, 1'b0);
      queue_column(SAMPLE_W'(200), 1'b0, 1'b0);
      settle();
      write_window('1);
      queue_column(SAMPLE_W'(7), 1'b0, 1'b0);
      queue_column(SAMPLE_W'(8), 1'b0, 1'b0);
      queue_column(SAMPLE_W'(9), 1'b1, 1'b0);
      settle();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         case (s)
            0: v = CFG_W'(2);
            1: v = CFG_W'(1);
            2: v = CFG_W'(MAX_WINDOW);
            3: v = CFG_W'(0);
            4: v = '1;
            5: v = CFG_W'(5);
            6: v = CFG_W'(MAX_WINDOW + 1);
            7: v = CFG_W'(3);
            8: v = CFG_W'($urandom_range(1, 16));
            default: v = CFG_W'($urandom_range(0, 127));
         endcase
         write_window(v);
         idle_on <= (s != 5);
         w     = clamp_window(v);
         n     = 0;
         first = 1;
         while (n < PER_SETTING) begin
            r = $urandom_range(0, 9);
            if (r < 7) len = w + $urandom_range(0, w + 4);
            else if (r < 8) len = (w > 1) ? $urandom_range(1, w - 1) : 1;
            else len = 1;
            queue_profile(len, 1, first || $urandom_range(0, 7) == 0);
            n += len;
            first = 0;
         end
         // Leave a profile open; the next register write has to restart it.
         if (s % 3 == 1) queue_profile($urandom_range(1, 2 * w), 0, 0);
         if (s == 0) hold_go = 1;
         settle();
      end

      $display("run covered %0d columns, %0d results, %0d profiles (%0d too short)",
               columns_sent, results_seen, profiles_seen, short_seen);
      $display("over %0d window settings, including zero and oversized windows",
               settings_seen);
      if (error_count == 0) begin
         $display("** centered_moving_average_stats_unit: PASSED **");
      end else begin
         $display("** centered_moving_average_stats_unit: FAILED **");
      end
      $finish;
   end

endmodule
